/* rtl/blup_pkg.sv */
// shared constants, types and helpers for the bilinear 4x upscaler
package blup_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int CoordW     = 10;
  localparam int SizeW      = 11;
  localparam int PixW       = 8;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;

  // register index, taken from paddr[2]
  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  localparam logic [SizeW-1:0] WidthReset  = SizeW'(MaxWidth);
  localparam logic [SizeW-1:0] HeightReset = SizeW'(MaxHeight);

  typedef struct packed {
    logic [CoordW-1:0] w_last;
    logic [CoordW-1:0] h_last;
    logic              restart;
  } cfg_t;

  // one 2x2 neighbourhood to be expanded into a 4x4 block
  typedef struct packed {
    logic [PixW-1:0]   f00;
    logic [PixW-1:0]   f01;
    logic [PixW-1:0]   f10;
    logic [PixW-1:0]   f11;
    logic [CoordW-1:0] bi;
    logic [CoordW-1:0] bj;
    logic              last;
  } job_t;

  // saturate a size register into 1..maxv and return size minus one
  function automatic logic [CoordW-1:0] size_last(input logic [SizeW-1:0] v,
                                                  input logic [SizeW-1:0] maxv);
    logic [SizeW-1:0] m1;
    m1 = v - SizeW'(1);
    if (v == '0) begin
      return '0;
    end else if (v > maxv) begin
      return CoordW'(maxv - SizeW'(1));
    end
    return m1[CoordW-1:0];
  endfunction

endpackage

/* rtl/blup_front.sv */
// front end: line store, counters, and splitting each pixel into block jobs
module blup_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  blup_pkg::cfg_t           cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               pixel_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output blup_pkg::job_t           q_job_o
);
  import blup_pkg::*;

  logic [PixW-1:0]   line_mem [MaxWidth];
  logic [PixW-1:0]   rd_q;
  logic              byp_q;
  logic [PixW-1:0]   byp_data_q;
  logic [CoordW-1:0] col_q, col_d, row_q, row_d;
  logic [PixW-1:0]   left_q, ul_q;
  logic [3:0]        mask_q, mask_new, sel, rest;
  logic [PixW-1:0]   p_q, up_q, lf_q, ulp_q;
  logic [CoordW-1:0] r_q, c_q;
  logic [PixW-1:0]   up;
  logic              accept, last_col, last_row;

  assign up       = byp_q ? byp_data_q : rd_q;
  assign last_col = (col_q == cfg_i.w_last);
  assign last_row = (row_q == cfg_i.h_last);

  // lowest pending block goes out first
  assign sel      = mask_q & (~mask_q + 4'd1);
  assign rest     = mask_q & ~sel;
  assign q_push_o = (mask_q != '0) && !q_full_i;

  assign in_stall_o = !((mask_q == '0) || (q_push_o && (rest == '0)));
  assign accept     = in_valid_i && !in_stall_o;

  assign mask_new[0] = (row_q != '0) && (col_q != '0);
  assign mask_new[1] = (row_q != '0) && last_col;
  assign mask_new[2] = last_row && (col_q != '0);
  assign mask_new[3] = last_row && last_col;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_i.restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + CoordW'(1);
      end else begin
        col_d = col_q + CoordW'(1);
      end
    end
  end

  always_comb begin
    q_job_o      = '0;
    q_job_o.last = (rest == '0);
    if (sel[0]) begin
      q_job_o.f00 = ulp_q;
      q_job_o.f01 = up_q;
      q_job_o.f10 = lf_q;
      q_job_o.f11 = p_q;
      q_job_o.bi  = r_q - CoordW'(1);
      q_job_o.bj  = c_q - CoordW'(1);
    end else if (sel[1]) begin
      q_job_o.f00 = up_q;
      q_job_o.f01 = up_q;
      q_job_o.f10 = p_q;
      q_job_o.f11 = p_q;
      q_job_o.bi  = r_q - CoordW'(1);
      q_job_o.bj  = c_q;
    end else if (sel[2]) begin
      q_job_o.f00 = lf_q;
      q_job_o.f01 = p_q;
      q_job_o.f10 = lf_q;
      q_job_o.f11 = p_q;
      q_job_o.bi  = r_q;
      q_job_o.bj  = c_q - CoordW'(1);
    end else begin
      q_job_o.f00 = p_q;
      q_job_o.f01 = p_q;
      q_job_o.f10 = p_q;
      q_job_o.f11 = p_q;
      q_job_o.bi  = r_q;
      q_job_o.bj  = c_q;
    end
  end

  // line store: read ahead at the next column, write the current one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[col_q] <= pixel_i;
    end
    rd_q <= line_mem[col_d];
  end

  // single-column image reads back the pixel written on the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= accept && (col_d == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= pixel_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
      ul_q   <= '0;
      mask_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        left_q <= pixel_i;
        ul_q   <= up;
        mask_q <= mask_new;
      end else if (q_push_o) begin
        mask_q <= rest;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q   <= pixel_i;
      up_q  <= up;
      lf_q  <= left_q;
      ulp_q <= ul_q;
      r_q   <= row_q;
      c_q   <= col_q;
    end
  end

`ifndef ASSERT_OFF
  a_counters_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_i.restart |-> (col_q <= cfg_i.w_last) && (row_q <= cfg_i.h_last))
    else $error("source position outside frame");

  a_push_clears_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o && !accept |=> $countones(mask_q) == $countones($past(mask_q)) - 1)
    else $error("pushed block not retired");

  a_last_job_ends_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o && q_job_o.last |-> !in_stall_o)
    else $error("front stalls after its last block");
`endif

endmodule

/* rtl/blup_queue.sv */
// short job queue between front and back
module blup_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  blup_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output blup_pkg::job_t job_o,
  output logic           empty_o
);
  import blup_pkg::*;

  job_t                 slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = slots[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_count_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != QueueCntW'(QueueDepth)) |->
      (QueuePtrW'(wr_ptr_q - rd_ptr_q) == cnt_q[QueuePtrW-1:0]))
    else $error("queue count disagrees with pointers");
`endif

endmodule

/* rtl/blup_back.sv */
// back end: coefficients per block and sixteen output beats per block
module blup_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  blup_pkg::job_t           job_i,
  input  logic                     q_empty_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               value_o,
  output logic [11:0]              out_row_o,
  output logic [11:0]              out_col_o,
  output logic                     last_o
);
  import blup_pkg::*;

  logic                     cur_valid_q;
  logic [3:0]               cnt_q;
  logic [PixW-1:0]          a_q, b_q, c_q, d_q;
  logic [CoordW-1:0]        bi_q, bj_q;
  logic                     last_q;
  logic                     out_load, cur_done;
  logic signed [PixW:0]     da, db, ta, tb;
  logic signed [PixW+1:0]   dc, tc;
  logic signed [PixW:0]     qa, qb;
  logic signed [PixW+1:0]   qc;
  logic [1:0]               dy, dx;
  logic [3:0]               dxy;
  logic [PixW-1:0]          val;

  // differences, divided with truncation toward zero
  always_comb begin
    da = $signed({1'b0, job_i.f10}) - $signed({1'b0, job_i.f00});
    db = $signed({1'b0, job_i.f01}) - $signed({1'b0, job_i.f00});
    dc = $signed({2'b0, job_i.f11}) - $signed({2'b0, job_i.f10})
       - $signed({2'b0, job_i.f01}) + $signed({2'b0, job_i.f00});
    ta = da + (da[PixW] ? 9'sd3 : 9'sd0);
    tb = db + (db[PixW] ? 9'sd3 : 9'sd0);
    tc = dc + (dc[PixW+1] ? 10'sd15 : 10'sd0);
    qa = ta >>> 2;
    qb = tb >>> 2;
    qc = tc >>> 4;
  end

  assign dy  = cnt_q[3:2];
  assign dx  = cnt_q[1:0];
  assign dxy = 4'({2'b0, dx} * {2'b0, dy});

  // only the low byte survives, so work modulo 256
  assign val = 8'(a_q * {6'b0, dy}) + 8'(b_q * {6'b0, dx})
             + 8'(c_q * {4'b0, dxy}) + d_q;

  assign out_load = cur_valid_q && (!out_valid_o || !out_stall_i);
  assign cur_done = out_load && (cnt_q == 4'hf);
  assign q_pop_o  = !q_empty_i && (!cur_valid_q || cur_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (q_pop_o) begin
        cur_valid_q <= 1'b1;
        cnt_q       <= '0;
      end else if (cur_done) begin
        cur_valid_q <= 1'b0;
        cnt_q       <= '0;
      end else if (out_load) begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      a_q    <= qa[PixW-1:0];
      b_q    <= qb[PixW-1:0];
      c_q    <= qc[PixW-1:0];
      d_q    <= job_i.f00;
      bi_q   <= job_i.bi;
      bj_q   <= job_i.bj;
      last_q <= job_i.last;
    end
    if (out_load) begin
      value_o   <= val;
      out_row_o <= {bi_q, dy};
      out_col_o <= {bj_q, dx};
      last_o    <= last_q && (cnt_q == 4'hf);
    end
  end

`ifndef ASSERT_OFF
  a_last_at_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> (out_row_o[1:0] == 2'd3) && (out_col_o[1:0] == 2'd3))
    else $error("last beat not at block corner");

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !cur_valid_q || cur_done)
    else $error("block replaced before finished");

  a_cnt_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (cnt_q != 4'hf) |=> cnt_q == $past(cnt_q) + 4'd1)
    else $error("beat counter skipped");
`endif

endmodule

/* rtl/bilinear_upscale_by_four.sv */
// top level of the bilinear 4x upscaler with its register port
//
// source pixels enter on in_valid_i/in_stall_o/pixel_i in raster order;
// a beat is taken when in_valid_i is high and in_stall_o is low.
// every source pixel yields 0, 16, 32 or 64 output beats on
// out_valid_o/out_stall_i with value_o, out_row_o, out_col_o and last_o;
// last_o marks the final beat caused by one source pixel.
// the front end keeps the previous row in a 1024-entry line store and
// turns each pixel into up to four block jobs, one per cycle while the
// queue has room, into a four-deep job queue; the back end expands one
// job into 16 beats. the back end sends one beat per cycle while
// out_stall_i is low; an interior pixel yields 16 beats, a right-edge
// or bottom-edge pixel 32 and the final pixel 64.
// image_width (address 0) and image_height (address 4) are written over
// the apb port; a write restarts the frame at row 0, column 0.
// reset sets both sizes to 1024 and starts a fresh frame; the line store
// needs no clearing since each entry is written before its value is used.
// a stall on the output holds the beat; the queue then fills and the
// input stalls until room returns.
module bilinear_upscale_by_four (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  value_o,
  output logic [11:0] out_row_o,
  output logic [11:0] out_col_o,
  output logic        last_o
);
  import blup_pkg::*;

  logic [SizeW-1:0] width_q, height_q;
  logic             cfg_wr;
  cfg_t             cfg;
  job_t             push_job, head_job;
  logic             q_push, q_pop, q_full, q_empty;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      RegImageWidth:  prdata = {21'b0, width_q};
      RegImageHeight: prdata = {21'b0, height_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegImageWidth:  width_q  <= pwdata[SizeW-1:0];
        RegImageHeight: height_q <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.w_last  = size_last(width_q, SizeW'(MaxWidth));
  assign cfg.h_last  = size_last(height_q, SizeW'(MaxHeight));
  assign cfg.restart = cfg_wr;

  blup_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_i    (pixel_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  blup_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (head_job),
    .empty_o (q_empty)
  );

  blup_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .last_o      (last_o)
  );

endmodule

/* bench/testbench.sv */
// self-checking testbench for the bilinear 4x upscaler: predictor, drivers and checks
module testbench;
  import blup_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles  = 20;
  localparam int RandomPixels  = 300;
  localparam int SatPixels     = 16;

  // predicts the 4x4 blocks produced by each source pixel and checks output beats
  class upscale_scoreboard;
    typedef struct packed {
      logic [7:0]  value;
      logic [11:0] row;
      logic [11:0] col;
      logic        last;
    } beat_t;

    beat_t            pending_beats[$];
    logic [7:0]       prev_row_px [MaxWidth];
    logic [7:0]       left_px;
    logic [7:0]       upper_left_px;
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [SizeW-1:0] width_reg;
    logic [SizeW-1:0] height_reg;
    int               errors;
    int               pixels_taken;
    int               beats_checked;
    int               size_writes;

    function new();
      for (int i = 0; i < MaxWidth; i++) prev_row_px[i] = '0;
      left_px       = '0;
      upper_left_px = '0;
      col_pos       = 0;
      row_pos       = 0;
      width_reg     = WidthReset;
      height_reg    = HeightReset;
      errors        = 0;
      pixels_taken  = 0;
      beats_checked = 0;
      size_writes   = 0;
    endfunction

    function int unsigned eff_size(logic [SizeW-1:0] v, int unsigned maxv);
      if (v == '0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    // a register write restarts the frame
    function void write_size(logic idx, logic [SizeW-1:0] v);
      if (idx == RegImageWidth) begin
        width_reg = v;
      end else begin
        height_reg = v;
      end
      col_pos = 0;
      row_pos = 0;
      size_writes++;
    endfunction

    function void add_block(int unsigned bi, int unsigned bj,
                            int f00, int f01, int f10, int f11);
      int    a;
      int    b;
      int    cxy;
      int    v;
      beat_t bt;
      a   = (f10 - f00) / 4;
      b   = (f01 - f00) / 4;
      cxy = (f11 - f10 - f01 + f00) / 16;
      for (int dy = 0; dy < 4; dy++) begin
        for (int dx = 0; dx < 4; dx++) begin
          v        = a * dy + b * dx + cxy * dx * dy + f00;
          bt.value = v[7:0];
          bt.row   = 12'(bi * 4 + dy);
          bt.col   = 12'(bj * 4 + dx);
          bt.last  = 1'b0;
          pending_beats.push_back(bt);
        end
      end
    endfunction

    function void note_pixel(logic [7:0] px);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      int          p;
      int          up;
      int          lf;
      int          ul;
      int          before_n;
      bit          at_last_col;
      bit          at_last_row;
      w = eff_size(width_reg, MaxWidth);
      h = eff_size(height_reg, MaxHeight);
      r = row_pos;
      c = col_pos;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      p  = px;
      up = prev_row_px[c];
      lf = left_px;
      ul = upper_left_px;
      at_last_col = (c == w - 1);
      at_last_row = (r == h - 1);
      before_n = pending_beats.size();
      // neighbours past the right or bottom edge repeat the edge pixel
      if (r >= 1 && c >= 1) add_block(r - 1, c - 1, ul, up, lf, p);
      if (r >= 1 && at_last_col) add_block(r - 1, c, up, up, p, p);
      if (at_last_row && c >= 1) add_block(r, c - 1, lf, p, lf, p);
      if (at_last_row && at_last_col) add_block(r, c, p, p, p, p);
      if (pending_beats.size() > before_n) begin
        pending_beats[pending_beats.size() - 1].last = 1'b1;
      end
      prev_row_px[c] = px;
      upper_left_px  = up[7:0];
      left_px        = px;
      if (at_last_col) begin
        col_pos = 0;
        row_pos = at_last_row ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
      pixels_taken++;
    endfunction

    function void compare_field(string field, beat_t want, logic [11:0] want_v,
                                logic [11:0] got_v);
      if (got_v !== want_v) begin
        errors++;
        $display("%0t: %s mismatch at out (%0d,%0d): expected %0d, actual %0d",
                 $time, field, want.row, want.col, want_v, got_v);
      end
    endfunction

    function void check_beat(logic [7:0] value, logic [11:0] row, logic [11:0] col,
                             logic last);
      beat_t want;
      beats_checked++;
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none, actual value=%0d row=%0d col=%0d last=%0b",
                 $time, value, row, col, last);
        return;
      end
      want = pending_beats.pop_front();
      compare_field("value", want, 12'(want.value), 12'(value));
      compare_field("out_row", want, want.row, row);
      compare_field("out_col", want, want.col, col);
      compare_field("last", want, 12'(want.last), 12'(last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  pixel_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  value_o;
  logic [11:0] out_row_o;
  logic [11:0] out_col_o;
  logic        last_o;

  upscale_scoreboard sb;
  bit quiet_in;
  bit quiet_out;
  int stall_left;
  int idle_cycles;
  int random_pixels;

  bilinear_upscale_by_four u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // output side: check each beat, then draw the stall before the next one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_beat(value_o, out_row_o, out_col_o, last_o);
      stall_left = quiet_out ? 0 : $urandom_range(0, 19);
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, WatchdogLimit);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [7:0] px);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(px);
  endtask

  // hold the input until every predicted beat is out, then let the front end settle
  task automatic wait_results_done(input int settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_size(input logic idx, input logic [SizeW-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {$urandom_range(0, 1) ? 21'h1fffff : 21'h0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_size(idx, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_size(input logic idx);
    logic [SizeW-1:0] want;
    want = (idx == RegImageWidth) ? sb.width_reg : sb.height_reg;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(want)) begin
      sb.errors++;
      $display("%0t: readback of register at %0d: expected %0d, actual %0d",
               $time, {idx, 2'b00}, want, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_sizes(input logic [SizeW-1:0] w, input logic [SizeW-1:0] h);
    wait_results_done(SettleCycles);
    write_size(RegImageWidth, w);
    write_size(RegImageHeight, h);
    read_size(RegImageWidth);
    read_size(RegImageHeight);
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [SizeW-1:0] rand_size();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SizeW'(1);
      default: return SizeW'($urandom_range(2, 7));
    endcase
  endfunction

  initial begin
    int frame_px;
    int count;
    int choice;
    sb          = new();
    stall_left  = 0;
    idle_cycles = 0;
    quiet_in    = 1'b0;
    quiet_out   = 1'b0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    pixel_i     = '0;
    out_stall_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sizes after reset, first row yields nothing
    read_size(RegImageWidth);
    read_size(RegImageHeight);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd17);

    // two-by-two frame with steep slopes of both signs
    set_sizes(SizeW'(2), SizeW'(2));
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);

    // zero width saturates to one: every pixel closes a whole frame
    set_sizes('0, SizeW'(1));
    send_pixel(8'd200);
    send_pixel(8'd7);

    set_sizes(SizeW'(1), SizeW'(3));
    send_pixel(8'd10);
    send_pixel(8'd250);
    send_pixel(8'd3);

    set_sizes(SizeW'(3), '0);
    send_pixel(8'd128);
    send_pixel(8'd1);
    send_pixel(8'd254);

    // oversized registers saturate to the largest frame, short runs without idling
    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    set_sizes(SizeW'(2047), SizeW'(2));
    for (int i = 0; i < SatPixels; i++) send_pixel(rand_pixel());
    set_sizes(SizeW'(2), SizeW'(1500));
    for (int i = 0; i < SatPixels; i++) send_pixel(rand_pixel());
    set_sizes(SizeW'(MaxWidth), SizeW'(MaxHeight));
    for (int i = 0; i < 6; i++) send_pixel(rand_pixel());

    // random frames, mostly whole, some cut short by a size write
    random_pixels = 0;
    while (random_pixels < RandomPixels) begin
      wait_results_done(SettleCycles);
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      choice = $urandom_range(0, 3);
      if (choice != 1) write_size(RegImageWidth, rand_size());
      if (choice != 0) write_size(RegImageHeight, rand_size());
      if ($urandom_range(0, 1)) read_size(choice == 1 ? RegImageHeight : RegImageWidth);
      frame_px = sb.eff_size(sb.width_reg, MaxWidth) * sb.eff_size(sb.height_reg, MaxHeight);
      count = frame_px * $urandom_range(1, 2);
      if ($urandom_range(0, 2) == 0) count += $urandom_range(1, frame_px);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 39) == 0) wait_results_done(0);
        send_pixel(rand_pixel());
      end
      random_pixels += count;
    end

    wait_results_done(SettleCycles);
    repeat (40) @(posedge clk_i);
    $display("covered %0d source pixels, %0d output beats, %0d size writes",
             sb.pixels_taken, sb.beats_checked, sb.size_writes);
    $display("sizes ran from one up to 1024 with saturating values on both registers");
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
